@@ hw/rtl/uitp_pkg.sv @@
package uitp_pkg;

  // default sizes
  localparam int DEF_VALUE_BITS = 64;
  localparam int DEF_MAX_LEN    = 4096;

  localparam int CH_W    = 8;
  localparam int RADIX_W = 6;
  localparam int DIGIT_W = 6;

  // radix register
  localparam logic [RADIX_W-1:0] RADIX_AUTO  = 6'd0;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] BASE_MIN    = 6'd2;
  localparam logic [RADIX_W-1:0] BASE_OCT    = 6'd8;
  localparam logic [RADIX_W-1:0] BASE_DEC    = 6'd10;
  localparam logic [RADIX_W-1:0] BASE_HEX    = 6'd16;
  localparam logic [RADIX_W-1:0] BASE_MAX    = 6'd36;

  // character codes
  localparam logic [CH_W-1:0] CH_TAB    = 8'd9;
  localparam logic [CH_W-1:0] CH_CR     = 8'd13;
  localparam logic [CH_W-1:0] CH_SPACE  = 8'd32;
  localparam logic [CH_W-1:0] CH_PLUS   = 8'h2b;
  localparam logic [CH_W-1:0] CH_MINUS  = 8'h2d;
  localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CH_W-1:0] CH_UP_A   = 8'h41;
  localparam logic [CH_W-1:0] CH_UP_Z   = 8'h5a;
  localparam logic [CH_W-1:0] CH_LO_A   = 8'h61;
  localparam logic [CH_W-1:0] CH_LO_Z   = 8'h7a;
  localparam logic [CH_W-1:0] CH_UP_X   = 8'h58;
  localparam logic [CH_W-1:0] CH_LO_X   = 8'h78;
  localparam logic [CH_W-1:0] LETTER_OFS = 8'd10;

  typedef enum logic [2:0] {
    PH_SPACE  = 3'd0,
    PH_LEAD   = 3'd1,
    PH_ZERO   = 3'd2,
    PH_DIGITS = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  // parse control state
  typedef struct packed {
    phase_t               phase;
    logic                 negative;
    logic [RADIX_W-1:0]   base;
    logic                 sat;
  } ctl_t;

  localparam ctl_t CTL_RESET = '{phase: PH_SPACE, negative: 1'b0, base: '0, sat: 1'b0};

  typedef struct packed {
    logic               ok;
    logic [DIGIT_W-1:0] val;
  } digit_t;

  // character to digit value, any base up to 36
  function automatic digit_t digit_of(input logic [CH_W-1:0] c);
    digit_t d;
    d.ok  = 1'b1;
    d.val = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d.val = DIGIT_W'(c - CH_ZERO);
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      d.val = DIGIT_W'(c - CH_LO_A + LETTER_OFS);
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      d.val = DIGIT_W'(c - CH_UP_A + LETTER_OFS);
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

@@ hw/rtl/unsigned_integer_text_parser.sv @@
// The input register holds a transferred character until the parse step takes it;
// a final character's result is then registered and shown on out_*.
// Throughput: one character per cycle while in_stall is low, set by the combinational multiply-add step.
// in_stall rises only while a final character waits on an unread result.
// Reset (rst_n low, synchronous): radix returns to 10, parse state cleared.
module unsigned_integer_text_parser
  import uitp_pkg::*;
#(
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  parameter int MAX_LEN    = DEF_MAX_LEN,
  localparam int POS_W     = $clog2(MAX_LEN + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [RADIX_W-1:0]    cfg_radix,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CH_W-1:0]       in_ch,
  input  logic                  in_last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VALUE_BITS-1:0] out_value,
  output logic [POS_W-1:0]      out_end_offset
);

  logic [RADIX_W-1:0]    radix_r;
  logic                  s1_valid_r, s1_valid_nxt;
  logic [CH_W-1:0]       s1_ch_r;
  logic                  s1_last_r;
  ctl_t                  ctl_r, ctl_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [POS_W-1:0]      dend_r, dend_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0] out_mag_r;
  logic                  out_neg_r;
  logic [POS_W-1:0]      out_dend_r;

  logic                  out_free;
  logic                  s1_take;
  logic                  in_xfer;
  logic [VALUE_BITS-1:0] res_mag;
  logic                  res_neg;
  logic [POS_W-1:0]      res_dend;

  // radix register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_wr_en) begin
      radix_r <= cfg_radix;
    end
  end

  // handshake: only a final character needs a free result slot
  assign out_free     = !out_valid_r || !out_stall;
  assign s1_take      = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall     = s1_valid_r && !s1_take;
  assign in_xfer      = in_valid && !in_stall;
  assign s1_valid_nxt = in_xfer || (s1_valid_r && !s1_take);

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_ch_r   <= in_ch;
      s1_last_r <= in_last;
    end
  end

  uitp_step #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_LEN    (MAX_LEN)
  ) u_step (
    .ch       (s1_ch_r),
    .last     (s1_last_r),
    .radix    (radix_r),
    .ctl_q    (ctl_r),
    .acc_q    (acc_r),
    .pos_q    (pos_r),
    .dend_q   (dend_r),
    .ctl_d    (ctl_nxt),
    .acc_d    (acc_nxt),
    .pos_d    (pos_nxt),
    .dend_d   (dend_nxt),
    .res_mag  (res_mag),
    .res_neg  (res_neg),
    .res_dend (res_dend)
  );

  // parse state advances once per consumed character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r  <= CTL_RESET;
      acc_r  <= '0;
      pos_r  <= '0;
      dend_r <= '0;
    end else if (s1_take) begin
      ctl_r  <= ctl_nxt;
      acc_r  <= acc_nxt;
      pos_r  <= pos_nxt;
      dend_r <= dend_nxt;
    end
  end

  // result register
  always_comb begin
    if (s1_take && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && s1_last_r) begin
      out_mag_r  <= res_mag;
      out_neg_r  <= res_neg;
      out_dend_r <= res_dend;
    end
  end

  // sign applied on the way out, modulo 2^VALUE_BITS
  assign out_valid      = out_valid_r;
  assign out_value      = out_neg_r ? (VALUE_BITS'(0) - out_mag_r) : out_mag_r;
  assign out_end_offset = out_dend_r;

  // a saturated value stays at all ones until the string ends
  a_sat_ones: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r.sat |-> (&acc_r))
    else $error("saturated flag without all-ones accumulator");

  // the digit end never runs past the character count
  a_dend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dend_r <= pos_r)
    else $error("digit end beyond position");

  // a consumed final character restarts the parse and posts a result
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_take && s1_last_r |=> ctl_r.phase == PH_SPACE && pos_r == '0 && out_valid_r)
    else $error("final character did not restart parse or post result");

  // input stalls only behind a final character blocked by an unread result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && s1_last_r && out_valid_r && out_stall)
    else $error("input stall without blocked result");

endmodule

@@ hw/rtl/uitp_step.sv @@
module uitp_step
  import uitp_pkg::*;
#(
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  parameter int MAX_LEN    = DEF_MAX_LEN,
  localparam int POS_W     = $clog2(MAX_LEN + 1)
) (
  input  logic [CH_W-1:0]       ch,
  input  logic                  last,
  input  logic [RADIX_W-1:0]    radix,
  input  ctl_t                  ctl_q,
  input  logic [VALUE_BITS-1:0] acc_q,
  input  logic [POS_W-1:0]      pos_q,
  input  logic [POS_W-1:0]      dend_q,
  output ctl_t                  ctl_d,
  output logic [VALUE_BITS-1:0] acc_d,
  output logic [POS_W-1:0]      pos_d,
  output logic [POS_W-1:0]      dend_d,
  output logic [VALUE_BITS-1:0] res_mag,
  output logic                  res_neg,
  output logic [POS_W-1:0]      res_dend
);

  localparam int PROD_W = VALUE_BITS + RADIX_W;
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_LEN);

  logic [CH_W-1:0]       c;
  logic [POS_W-1:0]      pos_n;
  logic [POS_W-1:0]      dend_n;
  logic [VALUE_BITS-1:0] acc_n;
  ctl_t                  ctl_n;
  logic                  do_lead;
  logic                  do_take;
  logic                  lead_zero;
  logic [RADIX_W-1:0]    lead_base;
  logic [RADIX_W-1:0]    take_base;
  digit_t                dg;
  logic [PROD_W-1:0]     prod;

  // past the length limit every character reads as a terminator
  always_comb begin
    if (pos_q >= POS_LIMIT) begin
      c     = '0;
      pos_n = pos_q;
    end else begin
      c     = ch;
      pos_n = pos_q + POS_W'(1);
    end
  end

  // base choice for the first character after any leading spaces and sign
  always_comb begin
    lead_zero = (c == CH_ZERO) && (radix == RADIX_AUTO || radix == BASE_HEX);
    if (radix == RADIX_AUTO) begin
      lead_base = BASE_DEC;
    end else if (radix >= BASE_MIN && radix <= BASE_MAX) begin
      lead_base = radix;
    end else begin
      lead_base = '0;
    end
  end

  // base in effect for a digit consumed in this step
  always_comb begin
    case (ctl_q.phase)
      PH_ZERO:   take_base = (radix == RADIX_AUTO) ? BASE_OCT : BASE_HEX;
      PH_DIGITS: take_base = ctl_q.base;
      default:   take_base = lead_base;
    endcase
  end

  assign dg   = digit_of(c);
  // overflow when acc * base + d does not fit
  assign prod = PROD_W'(acc_q) * PROD_W'(take_base) + PROD_W'(dg.val);

  // phase sequencing and digit accumulation
  always_comb begin
    ctl_n   = ctl_q;
    acc_n   = acc_q;
    dend_n  = dend_q;
    do_lead = 1'b0;
    do_take = 1'b0;

    case (ctl_q.phase)
      PH_SPACE: begin
        if ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE) begin
          ctl_n.phase = PH_SPACE;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          ctl_n.negative = (c == CH_MINUS);
          ctl_n.phase    = PH_LEAD;
        end else begin
          do_lead = 1'b1;
        end
      end
      PH_LEAD: begin
        do_lead = 1'b1;
      end
      PH_ZERO: begin
        ctl_n.phase = PH_DIGITS;
        if (c == CH_LO_X || c == CH_UP_X) begin
          ctl_n.base = BASE_HEX;
        end else begin
          ctl_n.base = (radix == RADIX_AUTO) ? BASE_OCT : BASE_HEX;
          dend_n     = pos_q;
          do_take    = 1'b1;
        end
      end
      PH_DIGITS: begin
        do_take = 1'b1;
      end
      default: begin
        ctl_n.phase = PH_DONE;
      end
    endcase

    if (do_lead) begin
      if (lead_zero) begin
        ctl_n.phase = PH_ZERO;
      end else begin
        ctl_n.base  = lead_base;
        ctl_n.phase = PH_DIGITS;
        do_take     = 1'b1;
      end
    end

    if (do_take) begin
      if (!dg.ok || dg.val >= take_base || take_base < BASE_MIN) begin
        ctl_n.phase = PH_DONE;
      end else begin
        if (!ctl_q.sat) begin
          if (prod[PROD_W-1:VALUE_BITS] != '0) begin
            acc_n     = '1;
            ctl_n.sat = 1'b1;
          end else begin
            acc_n = prod[VALUE_BITS-1:0];
          end
        end
        dend_n = pos_q + POS_W'(1);
      end
    end
  end

  // result and return to the idle parse state on the final character
  always_comb begin
    res_mag  = acc_n;
    res_neg  = ctl_n.negative;
    res_dend = (ctl_n.phase == PH_ZERO) ? pos_n : dend_n;
    if (last) begin
      ctl_d  = CTL_RESET;
      acc_d  = '0;
      pos_d  = '0;
      dend_d = '0;
    end else begin
      ctl_d  = ctl_n;
      acc_d  = acc_n;
      pos_d  = pos_n;
      dend_d = dend_n;
    end
  end

endmodule
